@@ rtl/assert_macros.svh @@
// ---------------------------------------------------------------------------
// Assertion macros shared by the checker files.
// Every property samples on clk and is off while rst_n is low.
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication within the same cycle
`define ASSERT_SAME(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication checked in the next cycle
`define ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ rtl/mabp_pkg.sv @@
// ---------------------------------------------------------------------------
// mabp_pkg
// Shared constants and types of the moving-average bipolar PWM block.
// ---------------------------------------------------------------------------
package mabp_pkg;

    // Window and sample geometry (window depth must be a power of two)
    localparam int WINDOW_DEPTH = 16;
    localparam int SAMPLE_BITS  = 12;
    localparam int SLOT_W       = $clog2(WINDOW_DEPTH);
    localparam int SUM_W        = SAMPLE_BITS + SLOT_W;
    localparam int DUTY_POS_W   = SAMPLE_BITS - 1;
    localparam int PWM_BITS     = 16;

    localparam logic [SAMPLE_BITS-1:0] MID_SCALE = SAMPLE_BITS'(1 << (SAMPLE_BITS - 1));
    localparam logic [SUM_W-1:0]       SUM_RESET =
        SUM_W'(WINDOW_DEPTH * (1 << (SAMPLE_BITS - 1)));
    localparam logic [PWM_BITS-1:0]    PERIOD_RESET = PWM_BITS'(1000);

    // Configuration port
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = PWM_BITS;
    localparam logic [CFG_ADDR_W-1:0] CFG_ENABLE = CFG_ADDR_W'(0);
    localparam logic [CFG_ADDR_W-1:0] CFG_PERIOD = CFG_ADDR_W'(1);

    // Output phase codes
    typedef enum logic [1:0] {
        PH_IDLE = 2'd0,
        PH_POS  = 2'd1,
        PH_NEG  = 2'd2
    } phase_t;

    // Result beat, last field in the low bits
    typedef struct packed {
        logic                   pad;
        logic                   drive_negative;
        logic                   drive_positive;
        logic [SAMPLE_BITS-1:0] duty_negative;
        logic [DUTY_POS_W-1:0]  duty_positive;
        phase_t                 phase;
        logic [SAMPLE_BITS-1:0] filtered;
    } out_beat_t;

    localparam int IN_TDATA_W  = ((SAMPLE_BITS + 7) / 8) * 8;
    localparam int OUT_TDATA_W = $bits(out_beat_t);

endpackage

@@ rtl/mabp_ram.sv @@
// ---------------------------------------------------------------------------
// mabp_ram
// Generic single-port-write, single-port-read RAM with registered read.
// ---------------------------------------------------------------------------
module mabp_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read, holds when not enabled
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

@@ rtl/moving_average_bipolar_pwm.sv @@
// ---------------------------------------------------------------------------
// moving_average_bipolar_pwm
// Sixteen-tap moving average of converter samples driving a bipolar PWM.
// ---------------------------------------------------------------------------
// Usage:
//   s_* carries one 12-bit sample per beat. m_* returns one result beat per
//   sample: filtered mean, phase, both duties and both channel drives for
//   the PWM counter value of that step.
//   cfg_we/cfg_addr/cfg_wdata write enable_modulation (index 0) and the
//   PWM period (index 1); write only while no sample is in flight.
// Path: an accepted sample passes the update stage, then the output
//   register, before its result beat shows on m_*.
// Throughput: one sample per cycle while m_tready is high. The ring sits
//   in a 16-entry RAM read as a sample enters the update stage; steps use
//   different slots, so the next sample's read never meets the current write.
// Reset: the window reads as mid-scale everywhere (per-entry valid bits),
//   the running sum is 16 x 2048, the PWM counter is zero, modulation is
//   off and the period is 1000. No clearing pass is needed.
// Stall: when m_tready is low the result stays in the output register, the
//   update stage holds one more sample and s_tready drops after that.
// ---------------------------------------------------------------------------
module moving_average_bipolar_pwm (
    input  logic                                 clk,
    input  logic                                 rst_n,
    // s_tdata: [11:0] sample
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    input  logic [mabp_pkg::IN_TDATA_W-1:0]      s_tdata,
    // m_tdata: [11:0] filtered, [13:12] phase, [24:14] duty_positive,
    //          [36:25] duty_negative, [37] drive_positive, [38] drive_negative
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    output logic [mabp_pkg::OUT_TDATA_W-1:0]     m_tdata,
    input  logic                                 cfg_we,
    input  logic [mabp_pkg::CFG_ADDR_W-1:0]      cfg_addr,
    input  logic [mabp_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

    import mabp_pkg::*;

    // Configuration registers
    logic                   enable_reg;
    logic [PWM_BITS-1:0]    period_reg;

    // Ring bookkeeping
    logic [SLOT_W-1:0]       slot_reg, slot_next;
    logic [WINDOW_DEPTH-1:0] entry_vld_reg;
    logic [SUM_W-1:0]        sum_reg, sum_next;
    logic [PWM_BITS-1:0]     pwm_count_reg, pwm_count_next;

    // Update stage
    logic                   p1_valid_reg;
    logic [SAMPLE_BITS-1:0] p1_sample_reg;
    logic [SLOT_W-1:0]      p1_slot_reg;
    logic                   p1_old_vld_reg;
    logic [SAMPLE_BITS-1:0] ram_rdata;

    // Output register
    logic                   out_valid_reg;
    out_beat_t              out_beat_reg, out_beat_next;

    logic                   in_fire;
    logic                   p1_go;
    logic [SAMPLE_BITS-1:0] old_sample;
    logic [SAMPLE_BITS-1:0] mean;
    logic [SAMPLE_BITS-1:0] diff_pos;
    logic [SAMPLE_BITS-1:0] diff_neg;
    logic [PWM_BITS-1:0]    count_inc;

    // Handshake
    assign p1_go    = p1_valid_reg && (!out_valid_reg || m_tready);
    assign s_tready = !p1_valid_reg || p1_go;
    assign in_fire  = s_tvalid && s_tready;
    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_beat_reg;

    // Sample ring memory
    mabp_ram #(
        .WIDTH (SAMPLE_BITS),
        .DEPTH (WINDOW_DEPTH)
    ) u_ring (
        .clk   (clk),
        .we    (p1_go),
        .waddr (p1_slot_reg),
        .wdata (p1_sample_reg),
        .re    (in_fire),
        .raddr (slot_reg),
        .rdata (ram_rdata)
    );

    // Configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            enable_reg <= 1'b0;
            period_reg <= PERIOD_RESET;
        end
        else if (cfg_we)
        begin
            if (cfg_addr == CFG_ENABLE)
            begin
                enable_reg <= cfg_wdata[0];
            end
            else if (cfg_addr == CFG_PERIOD)
            begin
                period_reg <= cfg_wdata[PWM_BITS-1:0];
            end
        end
    end

    // Next write slot, wraps at the window depth
    always_comb
    begin
        if (slot_reg == SLOT_W'(WINDOW_DEPTH - 1))
        begin
            slot_next = '0;
        end
        else
        begin
            slot_next = slot_reg + SLOT_W'(1);
        end
    end

    // Running sum, mean and PWM step
    always_comb
    begin
        old_sample = p1_old_vld_reg ? ram_rdata : MID_SCALE;
        sum_next   = sum_reg - SUM_W'(old_sample) + SUM_W'(p1_sample_reg);
        mean       = sum_next[SUM_W-1:SLOT_W];
        diff_pos   = mean - MID_SCALE;
        diff_neg   = MID_SCALE - mean;

        count_inc = pwm_count_reg + PWM_BITS'(1);
        if (count_inc >= period_reg)
        begin
            pwm_count_next = '0;
        end
        else
        begin
            pwm_count_next = count_inc;
        end

        out_beat_next               = '0;
        out_beat_next.filtered      = mean;
        out_beat_next.phase         = PH_IDLE;
        if (enable_reg)
        begin
            if (mean > MID_SCALE)
            begin
                out_beat_next.phase         = PH_POS;
                out_beat_next.duty_positive = diff_pos[DUTY_POS_W-1:0];
            end
            else
            begin
                out_beat_next.phase         = PH_NEG;
                out_beat_next.duty_negative = diff_neg;
            end
        end
        out_beat_next.drive_positive = pwm_count_next <
            {{(PWM_BITS - DUTY_POS_W){1'b0}}, out_beat_next.duty_positive};
        out_beat_next.drive_negative = pwm_count_next <
            {{(PWM_BITS - SAMPLE_BITS){1'b0}}, out_beat_next.duty_negative};
    end

    // Control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            slot_reg      <= '0;
            entry_vld_reg <= '0;
            sum_reg       <= SUM_RESET;
            pwm_count_reg <= '0;
            p1_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (in_fire)
            begin
                slot_reg <= slot_next;
            end
            if (p1_go)
            begin
                entry_vld_reg[p1_slot_reg] <= 1'b1;
                sum_reg                    <= sum_next;
                pwm_count_reg              <= pwm_count_next;
            end
            if (in_fire)
            begin
                p1_valid_reg <= 1'b1;
            end
            else if (p1_go)
            begin
                p1_valid_reg <= 1'b0;
            end
            if (p1_go)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (m_tready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            p1_sample_reg  <= s_tdata[SAMPLE_BITS-1:0];
            p1_slot_reg    <= slot_reg;
            p1_old_vld_reg <= entry_vld_reg[slot_reg];
        end
        if (p1_go)
        begin
            out_beat_reg <= out_beat_next;
        end
    end

endmodule

@@ rtl/mabp_checker.sv @@
// ---------------------------------------------------------------------------
// mabp_checker
// Port-level checks of the moving-average bipolar PWM block.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module mabp_checker (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 m_tvalid,
    input  logic                                 m_tready,
    input  logic [mabp_pkg::OUT_TDATA_W-1:0]     m_tdata
);

    import mabp_pkg::*;

    out_beat_t ob;
    logic      stalled;
    logic      pos_zero;
    logic      neg_zero;
    logic      drives_off;
    logic      is_idle;
    logic      is_pos;
    logic      pos_match;

    assign ob         = m_tdata;
    assign stalled    = m_tvalid && !m_tready;
    assign pos_zero   = (ob.duty_positive == '0);
    assign neg_zero   = (ob.duty_negative == '0);
    assign drives_off = !ob.drive_positive && !ob.drive_negative;
    assign is_idle    = m_tvalid && (ob.phase == PH_IDLE);
    assign is_pos     = m_tvalid && (ob.phase == PH_POS);
    assign pos_match  = (ob.filtered == MID_SCALE + SAMPLE_BITS'(ob.duty_positive));

    // A stalled result beat stays put
    `ASSERT_NEXT(a_out_hold, stalled, m_tvalid && $stable(m_tdata), "stalled beat changed")

    // Only one channel ever carries a nonzero duty
    `ASSERT_SAME(a_one_side, m_tvalid, pos_zero || neg_zero, "both duties nonzero")

    // Idle phase drives nothing
    `ASSERT_SAME(a_idle_off, is_idle, pos_zero && neg_zero && drives_off, "idle with duty")

    // Positive duty is the mean above mid-scale
    `ASSERT_SAME(a_pos_duty, is_pos, pos_match, "positive duty does not match mean")

endmodule

bind moving_average_bipolar_pwm mabp_checker u_mabp_checker (.*);

@@ test/moving_average_bipolar_pwm_tb.sv @@
// ---------------------------------------------------------------------------
// moving_average_bipolar_pwm_tb
// Self-checking bench for the moving-average bipolar PWM block. A short list
// of directed rows covers reset values, the zero-signal and idle cases, wide
// input words, unused register indexes and the period extremes. It is
// followed by random level runs, ramps and noise over several register
// settings. Result beats are checked field by field, typed rows against their
// table beat, others against a cycle-free filter, phase and PWM model kept here.
// ---------------------------------------------------------------------------
module moving_average_bipolar_pwm_tb;

    import mabp_pkg::*;

    localparam int HALF_PERIOD   = 2;
    localparam int CYCLE_LIMIT   = 200000;
    localparam int RANDOM_PHASES = 8;
    localparam int PHASE_ITEMS   = 216;
    localparam int LONG_HOLD     = 300;
    localparam int HOLD_AFTER    = 700;
    localparam int SETTLE_CYCLES = 8;

    // Register indexes the block does not decode
    localparam logic [CFG_ADDR_W-1:0] CFG_UNUSED2 = CFG_ADDR_W'(2);
    localparam logic [CFG_ADDR_W-1:0] CFG_UNUSED3 = CFG_ADDR_W'(3);

    typedef enum logic {
        ROW_SAMPLE = 1'b0,
        ROW_CFG    = 1'b1
    } row_kind_t;

    typedef struct {
        row_kind_t              kind;
        logic [CFG_ADDR_W-1:0]  addr;
        logic [15:0]            value;
        logic                   typed;
        out_beat_t              want;
    } stim_row_t;

    localparam int NUM_ROWS = 25;

    // Directed rows; typed beats hold for reset settings (modulation off)
    // and for the zero-signal case right after enabling.
    stim_row_t stim_rows [0:NUM_ROWS-1] = '{
        '{ROW_SAMPLE, CFG_ENABLE,  16'h0800, 1'b1,
          '{1'b0, 1'b0, 1'b0, 12'd0, 11'd0, PH_IDLE, 12'd2048}},
        '{ROW_SAMPLE, CFG_ENABLE,  16'h0000, 1'b1,
          '{1'b0, 1'b0, 1'b0, 12'd0, 11'd0, PH_IDLE, 12'd1920}},
        '{ROW_SAMPLE, CFG_ENABLE,  16'h0FFF, 1'b1,
          '{1'b0, 1'b0, 1'b0, 12'd0, 11'd0, PH_IDLE, 12'd2047}},
        '{ROW_SAMPLE, CFG_ENABLE,  16'hF800, 1'b1,
          '{1'b0, 1'b0, 1'b0, 12'd0, 11'd0, PH_IDLE, 12'd2047}},
        '{ROW_CFG,    CFG_ENABLE,  16'h0001, 1'b0, '0},
        '{ROW_SAMPLE, CFG_ENABLE,  16'h0801, 1'b1,
          '{1'b0, 1'b0, 1'b0, 12'd0, 11'd0, PH_NEG, 12'd2048}},
        '{ROW_CFG,    CFG_PERIOD,  16'h0001, 1'b0, '0},
        '{ROW_SAMPLE, CFG_ENABLE,  16'h0FFF, 1'b0, '0},
        '{ROW_SAMPLE, CFG_ENABLE,  16'h0FFF, 1'b0, '0},
        '{ROW_SAMPLE, CFG_ENABLE,  16'h0FFF, 1'b0, '0},
        '{ROW_SAMPLE, CFG_ENABLE,  16'h0FFF, 1'b0, '0},
        '{ROW_CFG,    CFG_PERIOD,  16'h0000, 1'b0, '0},
        '{ROW_SAMPLE, CFG_ENABLE,  16'h0000, 1'b0, '0},
        '{ROW_SAMPLE, CFG_ENABLE,  16'h0000, 1'b0, '0},
        '{ROW_SAMPLE, CFG_ENABLE,  16'h0000, 1'b0, '0},
        '{ROW_CFG,    CFG_UNUSED2, 16'h0000, 1'b0, '0},
        '{ROW_CFG,    CFG_UNUSED3, 16'h0005, 1'b0, '0},
        '{ROW_SAMPLE, CFG_ENABLE,  16'hA5A5, 1'b0, '0},
        '{ROW_SAMPLE, CFG_ENABLE,  16'h5A5A, 1'b0, '0},
        '{ROW_CFG,    CFG_PERIOD,  16'hFFFF, 1'b0, '0},
        '{ROW_SAMPLE, CFG_ENABLE,  16'hFFFF, 1'b0, '0},
        '{ROW_SAMPLE, CFG_ENABLE,  16'h0000, 1'b0, '0},
        '{ROW_SAMPLE, CFG_ENABLE,  16'h0FFF, 1'b0, '0},
        '{ROW_CFG,    CFG_ENABLE,  16'h0000, 1'b0, '0},
        '{ROW_SAMPLE, CFG_ENABLE,  16'h1234, 1'b0, '0}
    };

    // Period and enable for each random phase (phase 6 draws its period at random)
    logic [15:0] phase_period [0:RANDOM_PHASES-1] = '{
        16'd1000, 16'd1, 16'd65535, 16'd7, 16'd0, 16'd2048, 16'd0, 16'd300
    };
    logic        phase_enable [0:RANDOM_PHASES-1] = '{
        1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1
    };

    logic                      clk;
    logic                      rst_n;
    logic                      s_tvalid;
    logic                      s_tready;
    logic [IN_TDATA_W-1:0]     s_tdata;
    logic                      m_tvalid;
    logic                      m_tready;
    logic [OUT_TDATA_W-1:0]    m_tdata;
    logic                      cfg_we;
    logic [CFG_ADDR_W-1:0]     cfg_addr;
    logic [CFG_DATA_W-1:0]     cfg_wdata;

    // Model state: window, running sum, PWM counter and registers
    logic [SAMPLE_BITS-1:0]    win_ring [WINDOW_DEPTH];
    logic [SLOT_W-1:0]         win_slot;
    logic [SUM_W-1:0]          win_sum;
    logic [PWM_BITS-1:0]       pwm_cnt;
    logic                      mod_enable;
    logic [PWM_BITS-1:0]       pwm_per;

    out_beat_t                 expected_beats [$];
    int                        mismatches;
    int                        beats_seen;
    int                        cycle_count;

    // Sender burst shaping and sample generator state
    int                        burst_left;
    int                        gen_mode;
    int                        gen_left;
    int                        gen_level;
    int                        gen_step;

    moving_average_bipolar_pwm u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .cfg_we    (cfg_we),
        .cfg_addr  (cfg_addr),
        .cfg_wdata (cfg_wdata)
    );

    // Clock
    initial clk = 1'b0;
    always #HALF_PERIOD clk = ~clk;

    // Advance the filter and PWM model by one sample, return its beat
    function automatic out_beat_t filter_pwm_step(input logic [IN_TDATA_W-1:0] word);
        logic [SAMPLE_BITS-1:0] smp;
        logic [SAMPLE_BITS-1:0] mean;
        out_beat_t              beat;
        smp = word[SAMPLE_BITS-1:0];
        win_sum = win_sum - SUM_W'(win_ring[win_slot]) + SUM_W'(smp);
        win_ring[win_slot] = smp;
        win_slot = win_slot + 1'b1;
        mean = win_sum[SUM_W-1:SLOT_W];

        beat = '0;
        beat.filtered = mean;
        beat.phase    = PH_IDLE;
        if (mod_enable)
        begin
            if (mean > MID_SCALE)
            begin
                beat.phase         = PH_POS;
                beat.duty_positive = DUTY_POS_W'(mean - MID_SCALE);
            end
            else
            begin
                beat.phase         = PH_NEG;
                beat.duty_negative = MID_SCALE - mean;
            end
        end

        // counter advances first, then wraps at the period
        pwm_cnt = pwm_cnt + 1'b1;
        if (pwm_cnt >= pwm_per)
            pwm_cnt = '0;
        beat.drive_positive = (pwm_cnt < PWM_BITS'(beat.duty_positive));
        beat.drive_negative = (pwm_cnt < PWM_BITS'(beat.duty_negative));
        return beat;
    endfunction

    // Next random sample: level runs, ramps and noise, junk in the top nibble
    function automatic logic [IN_TDATA_W-1:0] next_sample();
        int pick;
        if (gen_left == 0)
        begin
            gen_mode = $urandom_range(0, 3);
            gen_left = $urandom_range(8, 40);
            pick     = $urandom_range(0, 3);
            gen_level = (pick == 0) ? 0 : (pick == 1) ? 4095 :
                        (pick == 2) ? 2048 : $urandom_range(0, 4095);
            gen_step  = $urandom_range(1, 200);
            if ($urandom_range(0, 1) == 1)
                gen_step = -gen_step;
        end
        gen_left = gen_left - 1;
        case (gen_mode)
            0: pick = gen_level;
            1:
            begin
                gen_level = gen_level + gen_step;
                if (gen_level > 4095 || gen_level < 0)
                begin
                    gen_step  = -gen_step;
                    gen_level = (gen_level > 4095) ? 4095 : 0;
                end
                pick = gen_level;
            end
            2: pick = $urandom_range(0, 4095);
            default:
            begin
                pick = gen_level + $urandom_range(0, 128) - 64;
                pick = (pick < 0) ? 0 : (pick > 4095) ? 4095 : pick;
            end
        endcase
        return {4'($urandom_range(0, 15)), SAMPLE_BITS'(pick)};
    endfunction

    // Offer one sample beat, inserting random gaps between bursts
    task automatic send_sample(input logic [IN_TDATA_W-1:0] word, input logic typed,
                               input out_beat_t want);
        int gap;
        out_beat_t beat;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(1, 32);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 8);
            if (gap > 0)
            begin
                @(negedge clk);
                s_tvalid <= 1'b0;
                repeat (gap - 1) @(negedge clk);
            end
        end
        burst_left = burst_left - 1;
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tdata  <= word;
        do
            @(posedge clk);
        while (!s_tready);
        beat = filter_pwm_step(word);
        expected_beats.push_back(typed ? want : beat);
    endtask

    // Stop offering and wait for every outstanding result
    task automatic drain();
        @(negedge clk);
        s_tvalid <= 1'b0;
        burst_left = 0;
        while (expected_beats.size() != 0)
            @(posedge clk);
        repeat (2) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_ADDR_W-1:0] addr, input logic [15:0] data);
        @(negedge clk);
        cfg_we    <= 1'b1;
        cfg_addr  <= addr;
        cfg_wdata <= data;
        if (addr == CFG_ENABLE)
            mod_enable = data[0];
        else if (addr == CFG_PERIOD)
            pwm_per = data;
        @(negedge clk);
        cfg_we <= 1'b0;
    endtask

    task automatic compare_field(input string name, input int want, input int got);
        if (want != got)
        begin
            mismatches = mismatches + 1;
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        end
    endtask

    // Result checker
    always @(posedge clk)
    begin
        out_beat_t got;
        out_beat_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = out_beat_t'(m_tdata);
            beats_seen = beats_seen + 1;
            if (expected_beats.size() == 0)
            begin
                mismatches = mismatches + 1;
                $display("%0t: unexpected result beat, expected none, actual %h",
                         $time, m_tdata);
            end
            else
            begin
                want = expected_beats.pop_front();
                compare_field("filtered",       want.filtered,       got.filtered);
                compare_field("phase",          want.phase,          got.phase);
                compare_field("duty_positive",  want.duty_positive,  got.duty_positive);
                compare_field("duty_negative",  want.duty_negative,  got.duty_negative);
                compare_field("drive_positive", want.drive_positive, got.drive_positive);
                compare_field("drive_negative", want.drive_negative, got.drive_negative);
                compare_field("pad",            want.pad,            got.pad);
            end
        end
    end

    // Receiver: rotating stall pattern, plus one long hold-off
    always @(negedge clk)
    begin
        int rx_cycle;
        int hold_left;
        bit held;
        if (rst_n)
        begin
            rx_cycle = rx_cycle + 1;
            if (!held && beats_seen >= HOLD_AFTER)
            begin
                held      = 1'b1;
                hold_left = LONG_HOLD;
            end
            if (hold_left > 0)
            begin
                hold_left = hold_left - 1;
                m_tready <= 1'b0;
            end
            else
            begin
                case ((rx_cycle / 97) % 4)
                    0: m_tready <= 1'b1;
                    1: m_tready <= ($urandom_range(0, 1) == 1);
                    2: m_tready <= ($urandom_range(0, 3) == 0);
                    default: m_tready <= ($urandom_range(0, 7) != 0);
                endcase
            end
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_count = cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // Stimulus
    initial
    begin
        int ph;
        int n;
        rst_n      = 1'b0;
        s_tvalid   = 1'b0;
        s_tdata    = '0;
        m_tready   = 1'b0;
        cfg_we     = 1'b0;
        cfg_addr   = CFG_ENABLE;
        cfg_wdata  = '0;
        mismatches = 0;
        beats_seen = 0;
        cycle_count = 0;
        burst_left = 0;
        gen_mode   = 0;
        gen_left   = 0;
        gen_level  = 0;
        gen_step   = 1;
        for (n = 0; n < WINDOW_DEPTH; n++)
            win_ring[n] = MID_SCALE;
        win_slot   = '0;
        win_sum    = SUM_RESET;
        pwm_cnt    = '0;
        mod_enable = 1'b0;
        pwm_per    = PERIOD_RESET;

        repeat (2) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed rows
        for (n = 0; n < NUM_ROWS; n++)
        begin
            if (stim_rows[n].kind == ROW_CFG)
            begin
                drain();
                write_reg(stim_rows[n].addr, stim_rows[n].value);
            end
            else
                send_sample(stim_rows[n].value, stim_rows[n].typed, stim_rows[n].want);
        end

        // Random phases under changing register settings
        for (ph = 0; ph < RANDOM_PHASES; ph++)
        begin
            drain();
            write_reg(CFG_ENABLE, {15'($urandom), phase_enable[ph]});
            write_reg(CFG_PERIOD, (ph == 6) ? 16'($urandom_range(2, 3000))
                                            : phase_period[ph]);
            if ($urandom_range(0, 1) == 1)
                write_reg(($urandom_range(0, 1) == 1) ? CFG_UNUSED2 : CFG_UNUSED3,
                          16'($urandom));
            for (n = 0; n < PHASE_ITEMS; n++)
                send_sample(next_sample(), 1'b0, '0);
        end

        drain();
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule
